/* hdl/rlrt_pkg.sv */
// Shared constants and codes for the run-length range table.
`default_nettype none
package rlrt_pkg;
	localparam int MAX_RUNS_DEF = 1024;
	localparam int MAX_RUN_DEF  = 255;
	localparam int POS_W        = 32;
	localparam int SYM_W        = 8;
	localparam int MODE_W       = 3;
	localparam int STATUS_W     = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_ADD    = 3'd1,
		MODE_LOOKUP = 3'd2,
		MODE_CNTSYM = 3'd3,
		MODE_CNTALL = 3'd4
	} mode_t;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;
endpackage
`default_nettype wire

/* hdl/rlrt_if.sv */
// Request and response channel interfaces of the run-length range table.
`default_nettype none
interface rlrt_req_if;
	logic                          valid;
	logic                          ready;
	logic [rlrt_pkg::MODE_W-1:0]   mode;
	logic [rlrt_pkg::POS_W-1:0]    position;
	logic [rlrt_pkg::POS_W-1:0]    run_length;
	logic [rlrt_pkg::SYM_W-1:0]    symbol;
	logic [rlrt_pkg::POS_W-1:0]    region_end;
	modport source (output valid, mode, position, run_length, symbol, region_end,
		input ready);
	modport sink (input valid, mode, position, run_length, symbol, region_end,
		output ready);
endinterface

interface rlrt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rlrt_pkg::STATUS_W-1:0] status;
	logic                          found;
	logic [rlrt_pkg::SYM_W-1:0]    found_symbol;
	logic [rlrt_pkg::POS_W-1:0]    count;
	modport source (output valid, status, found, found_symbol, count, input ready);
	modport sink (input valid, status, found, found_symbol, count, output ready);
endinterface
`default_nettype wire

/* hdl/run_length_range_table.sv */
// Run-length range table: run memory, sequencer and shared compare/add unit.
// Append splits a run into chunks of at most MAX_RUN; add position and unused modes
// go straight to the result. Lookup and counts read one run at a time from the read port.
// One beat is in work at a time; the response register frees the input side.
// Reset clears the run count and control; run memory holds no reset value.
`default_nettype none
module run_length_range_table #(
	parameter int MAX_RUNS = rlrt_pkg::MAX_RUNS_DEF,
	parameter int MAX_RUN  = rlrt_pkg::MAX_RUN_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rlrt_req_if.sink   req,
	rlrt_rsp_if.source rsp
);
	localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CNT_W = $clog2(MAX_RUNS + 1);
	localparam int LEN_W = $clog2(MAX_RUN + 1);
	localparam int PW    = rlrt_pkg::POS_W;
	localparam int SW    = rlrt_pkg::SYM_W;

	typedef enum logic [2:0] {S_IDLE, S_APP, S_RD, S_CHK, S_FIN} state_t;

	// run memory
	logic [PW-1:0]    mem_start [MAX_RUNS];
	logic [LEN_W-1:0] mem_len   [MAX_RUNS];
	logic [SW-1:0]    mem_sym   [MAX_RUNS];

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [PW-1:0]    last_start_q;
	logic [LEN_W-1:0] last_len_q;
	logic [SW-1:0]    last_sym_q;
	rlrt_pkg::mode_t  mode_q;
	logic [PW-1:0]    pos_q;
	logic [PW-1:0]    rend_q;
	logic [SW-1:0]    sym_q;
	logic [PW-1:0]    rest_q;
	logic [PW:0]      p_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] i_q;
	logic             first_q;
	logic [PW-1:0]    sum_q;
	logic [PW-1:0]    ch_start_q;
	logic [LEN_W-1:0] ch_len_q;
	logic [PW-1:0]    rd_start_q;
	logic [LEN_W-1:0] rd_len_q;
	logic [SW-1:0]    rd_sym_q;
	logic [rlrt_pkg::STATUS_W-1:0] res_status_q;
	logic             res_found_q;
	logic [SW-1:0]    res_fsym_q;
	logic             ov_q;
	logic [rlrt_pkg::STATUS_W-1:0] ov_status_q;
	logic             ov_found_q;
	logic [SW-1:0]    ov_fsym_q;
	logic [PW-1:0]    ov_count_q;

	logic             accept;
	logic             ov_load;
	logic             before_last;
	logic             can_extend;
	logic [LEN_W-1:0] chunk;
	logic [CNT_W-1:0] app_idx;
	logic             app_stop;
	logic             app_full;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [PW-1:0]    wstart;
	logic [LEN_W-1:0] wlen;
	logic [SW-1:0]    wsym;
	logic [PW:0]      rd_end;
	logic             hit;
	logic [PW-1:0]    s_val;
	logic [PW:0]      lim;
	logic [PW:0]      e_val;
	logic [PW+1:0]    sum_add;
	logic [PW-1:0]    sum_next;
	logic             match;
	logic             last_entry;

	assign accept  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign ov_load = (state_q == S_FIN) && (!ov_q || rsp.ready);

	// order and adjacency checks against the last run
	assign before_last = (count_q != '0) && (req.position < last_start_q);
	assign can_extend  = (count_q != '0) && (last_sym_q == req.symbol) &&
		(({1'b0, last_start_q} + (PW+1)'(last_len_q)) == {1'b0, req.position}) &&
		(last_len_q < LEN_W'(MAX_RUN));

	// append chunk sequencing
	assign chunk    = (rest_q < PW'(MAX_RUN)) ? rest_q[LEN_W-1:0] : LEN_W'(MAX_RUN);
	assign app_idx  = count_q + k_q;
	assign app_stop = (rest_q == '0) || p_q[PW];
	assign app_full = (app_idx == CNT_W'(MAX_RUNS));

	// shared compare/add unit for lookup and counting
	assign rd_end     = {1'b0, rd_start_q} + (PW+1)'(rd_len_q);
	assign hit        = (pos_q >= rd_start_q) && ({1'b0, pos_q} < rd_end);
	assign s_val      = (first_q && (pos_q > rd_start_q)) ? pos_q : rd_start_q;
	assign lim        = {1'b0, rend_q} + (PW+1)'(1);
	assign e_val      = (rd_end > lim) ? lim : rd_end;
	assign match      = (mode_q == rlrt_pkg::MODE_CNTALL) || (rd_sym_q == sym_q);
	assign sum_add    = {2'b00, sum_q} + {1'b0, e_val - {1'b0, s_val}};
	assign sum_next   = sum_add[PW+1:PW] != 2'b00 ? '1 : sum_add[PW-1:0];
	assign last_entry = ((i_q + CNT_W'(1)) >= count_q);

	// memory write port
	always_comb begin
		we     = 1'b0;
		waddr  = app_idx[IDX_W-1:0];
		wstart = p_q[PW-1:0];
		wlen   = chunk;
		wsym   = sym_q;
		if (state_q == S_APP && !app_stop && !app_full) begin
			we = 1'b1;
		end else if (accept && req.mode == rlrt_pkg::MODE_ADD && !before_last) begin
			if (can_extend) begin
				we     = 1'b1;
				waddr  = IDX_W'(count_q - CNT_W'(1));
				wstart = last_start_q;
				wlen   = last_len_q + LEN_W'(1);
				wsym   = last_sym_q;
			end else if (count_q != CNT_W'(MAX_RUNS)) begin
				we     = 1'b1;
				waddr  = count_q[IDX_W-1:0];
				wstart = req.position;
				wlen   = LEN_W'(1);
				wsym   = req.symbol;
			end
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_start[waddr] <= wstart;
			mem_len[waddr]   <= wlen;
			mem_sym[waddr]   <= wsym;
		end
		if (state_q == S_RD) begin
			rd_start_q <= mem_start[i_q[IDX_W-1:0]];
			rd_len_q   <= mem_len[i_q[IDX_W-1:0]];
			rd_sym_q   <= mem_sym[i_q[IDX_W-1:0]];
		end
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ov_q         <= 1'b0;
			mode_q       <= rlrt_pkg::MODE_APPEND;
			first_q      <= 1'b0;
			last_start_q <= '0;
			last_len_q   <= '0;
			last_sym_q   <= '0;
		end else begin
			// load the response register or drop the accepted beat
			if (ov_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q       <= req.position;
					rend_q      <= req.region_end;
					sym_q       <= req.symbol;
					rest_q      <= req.run_length;
					p_q         <= {1'b0, req.position};
					k_q         <= '0;
					sum_q       <= '0;
					first_q     <= 1'b1;
					res_found_q <= 1'b0;
					res_fsym_q  <= '0;
					case (req.mode)
					rlrt_pkg::MODE_APPEND: begin
						mode_q <= rlrt_pkg::MODE_APPEND;
						if (req.run_length != '0 && !before_last) begin
							res_status_q <= rlrt_pkg::ST_OK;
							state_q      <= S_APP;
						end else begin
							res_status_q <= (req.run_length != '0) ?
								rlrt_pkg::ST_ORDER : rlrt_pkg::ST_OK;
							state_q      <= S_FIN;
						end
					end
					rlrt_pkg::MODE_ADD: begin
						mode_q  <= rlrt_pkg::MODE_ADD;
						state_q <= S_FIN;
						if (before_last) begin
							res_status_q <= rlrt_pkg::ST_ORDER;
						end else if (can_extend) begin
							res_status_q <= rlrt_pkg::ST_OK;
							last_len_q   <= last_len_q + LEN_W'(1);
						end else if (count_q == CNT_W'(MAX_RUNS)) begin
							res_status_q <= rlrt_pkg::ST_FULL;
						end else begin
							res_status_q <= rlrt_pkg::ST_OK;
							count_q      <= count_q + CNT_W'(1);
							last_start_q <= req.position;
							last_len_q   <= LEN_W'(1);
							last_sym_q   <= req.symbol;
						end
					end
					rlrt_pkg::MODE_LOOKUP: begin
						mode_q       <= rlrt_pkg::MODE_LOOKUP;
						res_status_q <= rlrt_pkg::ST_OK;
						i_q          <= count_q - CNT_W'(1);
						state_q      <= (count_q != '0) ? S_RD : S_FIN;
					end
					rlrt_pkg::MODE_CNTSYM, rlrt_pkg::MODE_CNTALL: begin
						mode_q       <= rlrt_pkg::mode_t'(req.mode);
						res_status_q <= rlrt_pkg::ST_OK;
						i_q          <= '0;
						state_q      <= (count_q != '0 && req.region_end >= req.position) ?
							S_RD : S_FIN;
					end
					default: begin
						mode_q       <= rlrt_pkg::MODE_APPEND;
						res_status_q <= rlrt_pkg::ST_OK;
						state_q      <= S_FIN;
					end
					endcase
				end
			end
			S_APP: begin
				// write one chunk a cycle; commit only when all fit
				if (app_stop) begin
					count_q      <= app_idx;
					last_start_q <= ch_start_q;
					last_len_q   <= ch_len_q;
					last_sym_q   <= sym_q;
					state_q      <= S_FIN;
				end else if (app_full) begin
					res_status_q <= rlrt_pkg::ST_FULL;
					state_q      <= S_FIN;
				end else begin
					ch_start_q <= p_q[PW-1:0];
					ch_len_q   <= chunk;
					k_q        <= k_q + CNT_W'(1);
					rest_q     <= rest_q - PW'(chunk);
					p_q        <= p_q + (PW+1)'(MAX_RUN);
				end
			end
			S_RD: begin
				state_q <= S_CHK;
			end
			S_CHK: begin
				if (mode_q == rlrt_pkg::MODE_LOOKUP) begin
					// scan downwards; the highest holding run wins
					if (hit) begin
						res_found_q <= 1'b1;
						res_fsym_q  <= rd_sym_q;
						state_q     <= S_FIN;
					end else if (i_q == '0) begin
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q - CNT_W'(1);
						state_q <= S_RD;
					end
				end else if (first_q && rd_end <= {1'b0, pos_q}) begin
					// skip runs that end before the region
					i_q     <= i_q + CNT_W'(1);
					state_q <= last_entry ? S_FIN : S_RD;
				end else if (s_val > rend_q) begin
					state_q <= S_FIN;
				end else begin
					first_q <= 1'b0;
					if (match) begin
						sum_q <= sum_next;
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= last_entry ? S_FIN : S_RD;
				end
			end
			S_FIN: begin
				// hand the result over once the response register is free
				if (ov_load) begin
					ov_status_q <= res_status_q;
					ov_found_q  <= res_found_q;
					ov_fsym_q   <= res_fsym_q;
					ov_count_q  <= (mode_q == rlrt_pkg::MODE_CNTSYM ||
						mode_q == rlrt_pkg::MODE_CNTALL) ? sum_q : '0;
					state_q     <= S_IDLE;
				end
			end
			default: begin
				state_q <= S_IDLE;
			end
			endcase
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = ov_status_q;
	assign rsp.found        = ov_found_q;
	assign rsp.found_symbol = ov_fsym_q;
	assign rsp.count        = ov_count_q;

	// run count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RUNS))
		else $error("run count beyond table size");

	// a hit is only reported with status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == rlrt_pkg::ST_OK)
		else $error("found with bad status");

	// the run count stays unchanged while idle with no beat accepted
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !accept |=> $stable(count_q))
		else $error("run count moved while idle");
endmodule
`default_nettype wire
